FILE: sv/bcdm_pkg.sv
`timescale 1ns / 1ps

package bcdm_pkg;

    localparam int MAX_WIDTH   = 4096;
    localparam int COL_W       = $clog2(MAX_WIDTH);
    localparam int WIDTH_W     = COL_W + 1;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = WIDTH_W;
    localparam int TDATA_W     = 8;

    localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH     = CFG_INDEX_W'(0);
    localparam logic [CFG_INDEX_W-1:0] REG_BACKGROUND_MODE = CFG_INDEX_W'(1);

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_FLUSH = 1'b1;

    localparam logic [1:0] ROWS_NONE = 2'd0;
    localparam logic [1:0] ROWS_ONE  = 2'd1;
    localparam logic [1:0] ROWS_FULL = 2'd2;

endpackage

FILE: sv/binary_cross_dilation_mask_top.sv
`timescale 1ns / 1ps

// Channel   Dir  Signals                               Contents
// s_*       in   s_tvalid s_tready s_tdata s_tuser     pixel_bit, kind
// m_*       out  m_tvalid m_tready m_tdata m_tlast     mask_bit, end_of_image
// cfg_*     in   cfg_valid cfg_ready cfg_index cfg_data register writes
//
// One item per cycle when not stalled. The center-row store has two read ports
// that fetch the next column and the one after it at each transaction, so the
// window is ready by the following cycle. Results leave one row behind the input.
// Reset restores the width and mode registers and clears the column, row count
// and output valid; the line stores are not cleared and are never read before
// being written.
// An input transaction is taken whenever the output register is empty or drains.

module binary_cross_dilation_mask_top
    import bcdm_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [TDATA_W-1:0]     s_tdata,   // [0] pixel_bit, rest zero
    input  logic                   s_tuser,   // [0] kind
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [TDATA_W-1:0]     m_tdata,   // [0] mask_bit, rest zero
    output logic                   m_tlast,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic                center_mem [MAX_WIDTH];
    logic                upper_mem  [MAX_WIDTH];

    logic [WIDTH_W-1:0]  width_reg;
    logic                bg_mode_reg;
    logic [COL_W-1:0]    col_reg;
    logic [COL_W-1:0]    col_next;
    logic [1:0]          rows_reg;
    logic [1:0]          rows_next;

    logic                rd_a_reg;
    logic                rd_b_reg;
    logic                rd_u_reg;
    logic                fwd_a_reg;
    logic                fwd_b_reg;
    logic                fwd_u_reg;
    logic                wr_center_reg;
    logic                wr_upper_reg;
    logic                left_reg;

    logic                out_valid_reg;
    logic                out_mask_reg;
    logic                out_last_reg;

    logic [COL_W-1:0]    last_col_idx;
    logic                last_col;
    logic                s_accept;
    logic                cfg_accept;
    logic                flush;
    logic                pix;
    logic                wr_en;
    logic                produce;
    logic                center_wdata;
    logic [COL_W-1:0]    rd_addr;
    logic [COL_W-1:0]    rd_addr_b;
    logic                cur_center;
    logic                right_val;
    logic                up_val;
    logic                hit;

    assign cfg_ready  = 1'b1;
    assign cfg_accept = cfg_valid && cfg_ready;
    assign s_tready   = !out_valid_reg || m_tready;
    assign s_accept   = s_tvalid && s_tready;
    assign flush      = (s_tuser == KIND_FLUSH);
    assign pix        = s_tdata[0];

    // Clamp the programmed width to 1..MAX_WIDTH.
    always_comb
    begin
        if (width_reg == '0)
            last_col_idx = '0;
        else if (width_reg > WIDTH_W'(MAX_WIDTH))
            last_col_idx = COL_W'(MAX_WIDTH - 1);
        else
            last_col_idx = COL_W'(width_reg - WIDTH_W'(1));
    end

    assign last_col     = (col_reg == last_col_idx);
    assign wr_en        = s_accept && !(flush && rows_reg == ROWS_NONE);
    assign produce      = s_accept && (rows_reg != ROWS_NONE);
    assign center_wdata = flush ? 1'b0 : pix;
    assign rd_addr      = last_col ? '0 : col_reg + COL_W'(1);
    assign rd_addr_b    = rd_addr + COL_W'(1);

    // Take same-edge writes in place of stale read data.
    assign cur_center = fwd_a_reg ? wr_center_reg : rd_a_reg;
    assign right_val  = fwd_b_reg ? wr_center_reg : rd_b_reg;
    assign up_val     = fwd_u_reg ? wr_upper_reg  : rd_u_reg;

    always_comb
    begin
        hit = (cur_center == bg_mode_reg);
        if (rows_reg == ROWS_FULL && up_val == bg_mode_reg)
            hit = 1'b1;
        if (col_reg != '0 && left_reg == bg_mode_reg)
            hit = 1'b1;
        if (!last_col && right_val == bg_mode_reg)
            hit = 1'b1;
        if (!flush && pix == bg_mode_reg)
            hit = 1'b1;
    end

    always_comb
    begin
        col_next  = col_reg;
        rows_next = rows_reg;
        if (wr_en)
        begin
            if (last_col)
            begin
                col_next = '0;
                if (flush)
                    rows_next = ROWS_NONE;
                else if (rows_reg != ROWS_FULL)
                    rows_next = rows_reg + 2'd1;
            end
            else
            begin
                col_next = col_reg + COL_W'(1);
            end
        end
    end

    // Line stores: write the current column, prefetch the next window.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            center_mem[col_reg] <= center_wdata;
            upper_mem[col_reg]  <= cur_center;
        end
        if (s_accept)
        begin
            rd_a_reg      <= center_mem[rd_addr];
            rd_b_reg      <= center_mem[rd_addr_b];
            rd_u_reg      <= upper_mem[rd_addr];
            fwd_a_reg     <= wr_en && (rd_addr == col_reg);
            fwd_b_reg     <= wr_en && (rd_addr_b == col_reg);
            fwd_u_reg     <= wr_en && (rd_addr == col_reg);
            wr_center_reg <= center_wdata;
            wr_upper_reg  <= cur_center;
        end
        if (wr_en)
            left_reg <= cur_center;
    end

    always_ff @(posedge clk)
    begin
        if (produce)
        begin
            out_mask_reg <= hit;
            out_last_reg <= flush && last_col;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= WIDTH_W'(MAX_WIDTH);
            bg_mode_reg   <= 1'b1;
            col_reg       <= '0;
            rows_reg      <= ROWS_NONE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (produce)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;

            // Restart the image on a width write.
            if (cfg_accept && cfg_index == REG_IMAGE_WIDTH)
            begin
                width_reg <= cfg_data;
                col_reg   <= '0;
                rows_reg  <= ROWS_NONE;
            end
            else
            begin
                col_reg  <= col_next;
                rows_reg <= rows_next;
            end

            if (cfg_accept && cfg_index == REG_BACKGROUND_MODE)
                bg_mode_reg <= cfg_data[0];
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(TDATA_W-1){1'b0}}, out_mask_reg};
    assign m_tlast  = out_last_reg;

`ifndef SYNTH
    a_rows_saturate: assert property (@(posedge clk) disable iff (!rst_n)
        rows_reg != 2'd3)
        else $error("row count beyond saturation");

    a_col_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        !(cfg_accept && cfg_index == REG_IMAGE_WIDTH) |=> col_reg <= last_col_idx
            || $past(cfg_accept))
        else $error("column past the last column");

    a_result_from_item: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_accept) && $past(rows_reg != ROWS_NONE))
        else $error("result without an accepted item");

    a_ignored_flush: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && flush && rows_reg == ROWS_NONE && !cfg_accept)
            |=> rows_reg == ROWS_NONE && $stable(col_reg))
        else $error("ignored flush changed state");
`endif

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import bcdm_pkg::*;

    localparam int DRAIN_CYCLES = 16;
    localparam int MAX_REPORTS  = 10;
    // indexes the block does not decode; writes to them must change nothing
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = CFG_INDEX_W'(2);
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = CFG_INDEX_W'(3);

    typedef struct packed {
        logic kind;
        logic pixel_bit;
    } scan_item_t;

    typedef struct packed {
        logic mask_bit;
        logic end_of_image;
    } mask_result_t;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [TDATA_W-1:0]     s_tdata   = '0;
    logic                   s_tuser   = KIND_PIXEL;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [TDATA_W-1:0]     m_tdata;
    logic                   m_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    // stimulus and scoreboard
    scan_item_t   scan_queue[$];
    mask_result_t expected_masks[$];
    logic         in_taken      = 1'b0;
    int           send_idle_pct = 11;
    int           recv_idle_pct = 81;
    int           scan_width    = MAX_WIDTH;
    int           items_queued  = 0;
    int           items_taken   = 0;
    int           results_seen  = 0;
    int           images_done   = 0;
    int           reg_writes    = 0;
    int           mismatches    = 0;

    // predictor state
    bit           upper_row [MAX_WIDTH];
    bit           center_row [MAX_WIDTH];
    int           col_pos     = 0;
    int           width_used  = MAX_WIDTH;
    logic [1:0]   rows_done   = ROWS_NONE;
    logic         target_bit  = 1'b1;

    binary_cross_dilation_mask_top i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void apply_reg_write(logic [CFG_INDEX_W-1:0] index,
                                            logic [CFG_DATA_W-1:0] data);
        if (index == REG_IMAGE_WIDTH)
        begin
            if (data == 0)
                width_used = 1;
            else if (data > MAX_WIDTH)
                width_used = MAX_WIDTH;
            else
                width_used = int'(data);
            col_pos   = 0;
            rows_done = ROWS_NONE;
        end
        else if (index == REG_BACKGROUND_MODE)
        begin
            target_bit = data[0];
        end
    endfunction

    // Advance the line window by one transaction; queue the mask bit it releases.
    function automatic void dilate_pixel(logic kind, logic pix);
        int           c;
        logic         flush;
        logic         last_col;
        mask_result_t r;
        flush = (kind == KIND_FLUSH);
        c = (col_pos >= width_used) ? 0 : col_pos;
        last_col = (c + 1 == width_used);
        if (flush && rows_done == ROWS_NONE)
            return;
        if (rows_done != ROWS_NONE)
        begin
            r.mask_bit = (center_row[c] == target_bit)
                      || (rows_done == ROWS_FULL && upper_row[c] == target_bit)
                      || (c > 0 && upper_row[c-1] == target_bit)
                      || (!last_col && center_row[c+1] == target_bit)
                      || (!flush && pix == target_bit);
            r.end_of_image = flush && last_col;
            expected_masks.insert(expected_masks.size(), r);
        end
        upper_row[c]  = center_row[c];
        center_row[c] = flush ? 1'b0 : pix;
        if (last_col)
        begin
            col_pos = 0;
            if (flush)
                rows_done = ROWS_NONE;
            else if (rows_done == ROWS_NONE)
                rows_done = ROWS_ONE;
            else
                rows_done = ROWS_FULL;
        end
        else
        begin
            col_pos = c + 1;
        end
    endfunction

    function automatic void log_mismatch(string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: mismatch: %s", $realtime, msg);
    endfunction

    // driver: hold a transaction until taken, then load the next or idle
    always @(negedge clk)
    begin
        scan_item_t nxt;
        if (rst_n)
        begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
            if (!s_tvalid || in_taken)
            begin
                if (scan_queue.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    nxt = scan_queue.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= TDATA_W'(nxt.pixel_bit);
                    s_tuser  <= nxt.kind;
                end
                else
                begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        mask_result_t want;
        if (rst_n)
        begin
            in_taken <= s_tvalid && s_tready;
            if (cfg_valid && cfg_ready)
            begin
                reg_writes++;
                apply_reg_write(cfg_index, cfg_data);
            end
            if (s_tvalid && s_tready)
            begin
                items_taken++;
                dilate_pixel(s_tuser, s_tdata[0]);
            end
            if (m_tvalid && m_tready)
            begin
                results_seen++;
                if (m_tlast)
                    images_done++;
                if (expected_masks.size() == 0)
                begin
                    log_mismatch($sformatf("unexpected result tdata=%h tlast=%b",
                                           m_tdata, m_tlast));
                end
                else
                begin
                    want = expected_masks.pop_front();
                    if (m_tdata !== TDATA_W'(want.mask_bit) || m_tlast !== want.end_of_image)
                        log_mismatch($sformatf("result %0d: exp %h/%b, got %h/%b",
                                               results_seen, TDATA_W'(want.mask_bit),
                                               want.end_of_image, m_tdata, m_tlast));
                end
            end
        end
    end

    task automatic push_item(logic kind, logic pix);
        scan_item_t it;
        it.kind      = kind;
        it.pixel_bit = pix;
        scan_queue.insert(scan_queue.size(), it);
        items_queued++;
    endtask

    task automatic push_row(logic [15:0] bits, int n);
        for (int i = 0; i < n; i++)
            push_item(KIND_PIXEL, bits[i]);
    endtask

    task automatic push_image(int w, int rows, int density);
        repeat (rows * w) push_item(KIND_PIXEL, $urandom_range(99) < density);
        repeat (w) push_item(KIND_FLUSH, 1'($urandom_range(1)));
    endtask

    // wait for the pipe to empty so a register write lands on an idle block
    task automatic settle();
        while (scan_queue.size() != 0 || s_tvalid || expected_masks.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] index, int value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= CFG_DATA_W'(value);
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_phase(int budget, int send_pct, int recv_pct);
        int start;
        int pick;
        int density;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        start = items_queued;
        while (items_queued - start < budget)
        begin
            pick = $urandom_range(99);
            case ($urandom_range(3))
                0: density = 3;
                1: density = 50;
                2: density = 97;
                default: density = $urandom_range(100);
            endcase
            if (pick < 25)
            begin
                settle();
                if ($urandom_range(19) == 0)
                begin
                    write_reg(REG_IMAGE_WIDTH, 0);
                    scan_width = 1;
                end
                else
                begin
                    scan_width = ($urandom_range(9) == 0) ? $urandom_range(13, 48)
                                                          : $urandom_range(1, 12);
                    write_reg(REG_IMAGE_WIDTH, scan_width);
                end
                if ($urandom_range(1))
                    write_reg(REG_BACKGROUND_MODE, $urandom_range(1));
                if (pick < 3)
                    write_reg(pick[0] ? REG_SPARE_A : REG_SPARE_B, $urandom_range(8191));
            end
            else if (pick < 82)
            begin
                push_image(scan_width, $urandom_range(1, 5), density);
            end
            else
            begin
                // broken stream: stray flushes mid-row, truncated rows
                repeat ($urandom_range(1, 2 * scan_width + 2))
                    push_item($urandom_range(3) == 0 ? KIND_FLUSH : KIND_PIXEL,
                              $urandom_range(99) < density);
            end
        end
        settle();
    endtask

    initial
    begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // reset setting: full width, background mode
        push_item(KIND_FLUSH, 1'b1);    // no complete row yet: dropped
        push_row(16'b101, 3);
        settle();

        // zero width runs as a single column
        write_reg(REG_IMAGE_WIDTH, 0);
        write_reg(REG_SPARE_A, 8191);
        push_row(16'b010, 3);
        push_item(KIND_FLUSH, 1'b0);
        settle();

        write_reg(REG_IMAGE_WIDTH, 3);
        write_reg(REG_BACKGROUND_MODE, 0);
        push_row(16'b111, 3);
        push_row(16'b011, 3);
        push_row(16'b111, 3);
        repeat (3) push_item(KIND_FLUSH, 1'b1);
        push_item(KIND_FLUSH, 1'b0);    // image already closed: dropped
        settle();
        scan_width = 3;

        run_phase(400, 11, 81);
        run_phase(400, 81, 11);
        run_phase(400, 0, 0);

        // widest setting: an exact write, then an oversize one that clamps
        write_reg(REG_IMAGE_WIDTH, MAX_WIDTH);
        write_reg(REG_BACKGROUND_MODE, 1);
        push_row(16'b10110, 5);
        settle();
        write_reg(REG_IMAGE_WIDTH, 8191);
        write_reg(REG_SPARE_B, 0);
        push_row(16'b0110, 4);
        push_item(KIND_FLUSH, 1'b1);    // first row still open: dropped
        settle();

        $display("Covered %0d pixel and flush transactions, %0d register writes,",
                 items_taken, reg_writes);
        $display("widths 1 to 48 in both modes; %0d mask bits checked, %0d images closed.",
                 results_seen, images_done);
        if (mismatches == 0 && expected_masks.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: files.f
sv/bcdm_pkg.sv
sv/binary_cross_dilation_mask_top.sv
verif/tb_top.sv
